### rtl/core/flow_pulse_detector_assert.svh
// ----------------------------------------------------------------------------
// Flow pulse detector assertion macros
// Shared property wrappers for the concurrent checks of the detector core.
// ----------------------------------------------------------------------------
`ifndef FLOW_PULSE_DETECTOR_ASSERT_SVH
`define FLOW_PULSE_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPD_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPD_ASSERT_NXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fpd_pkg.sv
// ----------------------------------------------------------------------------
// Flow pulse detector package
// Widths, constants and register codes of the flow pulse detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpd_pkg;

    localparam int CNT16_W = 16;
    localparam int SUM_W   = 32;
    localparam int NUM_W   = 40;   // 16-bit count times the 24-bit rate constant
    localparam int IN_W    = 16;
    localparam int OUT_W   = 216;  // 209 payload bits padded to whole bytes
    localparam int PAD_W   = OUT_W - 1 - CNT16_W - 6 * SUM_W;

    // 60000 ms per minute times 256 for the Q24.8 fraction.
    localparam logic [23:0] RATE_K = 24'd15360000;

    localparam int MUL_STEPS = CNT16_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT16_W-1:0] MIN_PULSES_RST = 16'd10;
    localparam logic [CNT16_W-1:0] PPG_RST        = 16'd1000;

    typedef enum logic
    {
        CFG_MIN_PULSES = 1'b0,
        CFG_PULSES_PER_GALLON = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        CMD_PULSE  = 1'b0,
        CMD_PERIOD = 1'b1
    } cmd_t;

endpackage

### rtl/core/flow_pulse_detector.sv
// ----------------------------------------------------------------------------
// Flow pulse detector
// Counts flow sensor edges, tracks flow runs and totals, and reports a rate.
// ----------------------------------------------------------------------------
// A pulse transfer gives no result. A period transfer passes the accept,
// the bit-serial multiplier that forms the rate numerator and denominator
// (run and total counters update in its first two steps), the restoring
// divider that yields one quotient bit per cycle, and a load step that waits
// for a free output register before its result is loaded there. Input is
// taken only while the sequencer is idle; pulse transfers are still taken
// while a finished result waits downstream.
`timescale 1ns / 1ps

module flow_pulse_detector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] period_ms
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] flowing, [16:1] last_pulses, [48:17] run_pulses, [80:49] run_ms,
    // [112:81] total_flow_pulses, [144:113] total_flow_ms,
    // [176:145] flow_count, [208:177] rate_gpm_q8, [215:209] zero
    output logic [215:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam int C_W = fpd_pkg::CNT16_W;
    localparam int S_W = fpd_pkg::SUM_W;
    localparam int N_W = fpd_pkg::NUM_W;
    localparam int T_W = fpd_pkg::STEP_W;

    state_t         state_reg, state_next;
    logic [T_W-1:0] step_reg, step_next;

    logic [C_W-1:0] min_pulses_reg;
    logic [C_W-1:0] ppg_reg;

    logic [C_W-1:0] edge_count_reg, edge_count_next;
    logic [C_W-1:0] lat_pulses_reg, lat_pulses_next;
    logic [C_W-1:0] lat_period_reg, lat_period_next;
    logic           rate_zero_reg, rate_zero_next;
    logic [C_W-1:0] p_shift_reg, p_shift_next;
    logic [C_W-1:0] t_shift_reg, t_shift_next;
    logic [N_W-1:0] nq_reg, nq_next;
    logic [S_W-1:0] den_reg, den_next;
    logic [S_W-1:0] rem_reg, rem_next;

    logic [S_W-1:0] run_p_reg, run_p_next;
    logic [S_W-1:0] run_t_reg, run_t_next;
    logic           flag_reg, flag_next;
    logic [S_W-1:0] tot_p_reg, tot_p_next;
    logic [S_W-1:0] tot_t_reg, tot_t_next;
    logic [S_W-1:0] flows_reg, flows_next;

    logic                          out_valid_reg, out_valid_next;
    logic [fpd_pkg::OUT_W-1:0]     out_data_reg, out_data_next;

    logic           in_fire;
    logic           out_free;
    logic [S_W:0]   rem_shift;
    logic [S_W:0]   rem_diff;
    logic           q_bit;
    logic [S_W-1:0] rate;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // One restoring division step: bring down the next numerator bit.
    assign rem_shift = {rem_reg, nq_reg[N_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        if (rate_zero_reg)
            rate = '0;
        else if (|nq_reg[N_W-1:S_W])
            rate = '1;
        else
            rate = nq_reg[S_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        edge_count_next = edge_count_reg;
        lat_pulses_next = lat_pulses_reg;
        lat_period_next = lat_period_reg;
        rate_zero_next  = rate_zero_reg;
        p_shift_next    = p_shift_reg;
        t_shift_next    = t_shift_reg;
        nq_next         = nq_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        run_p_next      = run_p_reg;
        run_t_next      = run_t_reg;
        flag_next       = flag_reg;
        tot_p_next      = tot_p_reg;
        tot_t_next      = tot_t_reg;
        flows_next      = flows_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == fpd_pkg::CMD_PULSE)
                    begin
                        if (edge_count_reg != '1)
                            edge_count_next = edge_count_reg + 1'b1;
                    end
                    else
                    begin
                        lat_pulses_next = edge_count_reg;
                        lat_period_next = s_axis_tdata;
                        rate_zero_next  = (edge_count_reg == '0) || (s_axis_tdata == '0);
                        p_shift_next    = edge_count_reg;
                        t_shift_next    = s_axis_tdata;
                        edge_count_next = '0;
                        nq_next         = '0;
                        den_next        = '0;
                        step_next       = '0;
                        state_next      = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                // Shift-and-add multipliers, most significant bit first.
                nq_next  = {nq_reg[N_W-2:0], 1'b0}
                         + (p_shift_reg[C_W-1] ? {16'd0, fpd_pkg::RATE_K} : '0);
                den_next = {den_reg[S_W-2:0], 1'b0}
                         + (t_shift_reg[C_W-1] ? {16'd0, ppg_reg} : '0);
                p_shift_next = {p_shift_reg[C_W-2:0], 1'b0};
                t_shift_next = {t_shift_reg[C_W-2:0], 1'b0};

                // The run counters update in step zero, the totals in step one.
                if (step_reg == '0)
                begin
                    if (lat_pulses_reg != '0)
                    begin
                        run_p_next = run_p_reg + {16'd0, lat_pulses_reg};
                        run_t_next = run_t_reg + {16'd0, lat_period_reg};
                    end
                    else
                    begin
                        run_p_next = '0;
                        run_t_next = '0;
                        flag_next  = 1'b0;
                    end
                end
                else if (step_reg == T_W'(1))
                begin
                    if ((lat_pulses_reg != '0) && (run_p_reg >= {16'd0, min_pulses_reg}))
                    begin
                        if (!flag_reg)
                        begin
                            flag_next  = 1'b1;
                            flows_next = flows_reg + 1'b1;
                            tot_p_next = tot_p_reg + run_p_reg;
                            tot_t_next = tot_t_reg + run_t_reg;
                        end
                        else
                        begin
                            tot_p_next = tot_p_reg + {16'd0, lat_pulses_reg};
                            tot_t_next = tot_t_reg + {16'd0, lat_period_reg};
                        end
                    end
                end

                if (step_reg == T_W'(fpd_pkg::MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_DIV:
            begin
                rem_next = q_bit ? rem_diff[S_W-1:0] : rem_shift[S_W-1:0];
                nq_next  = {nq_reg[N_W-2:0], q_bit};
                if (step_reg == T_W'(fpd_pkg::DIV_STEPS - 1))
                    state_next = ST_DONE;
                else
                    step_next = step_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{fpd_pkg::PAD_W{1'b0}}, rate, flows_reg, tot_t_reg,
                                      tot_p_reg, run_t_reg, run_p_reg, lat_pulses_reg,
                                      flag_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            min_pulses_reg <= fpd_pkg::MIN_PULSES_RST;
            ppg_reg        <= fpd_pkg::PPG_RST;
            edge_count_reg <= '0;
            lat_pulses_reg <= '0;
            lat_period_reg <= '0;
            rate_zero_reg  <= 1'b1;
            run_p_reg      <= '0;
            run_t_reg      <= '0;
            flag_reg       <= 1'b0;
            tot_p_reg      <= '0;
            tot_t_reg      <= '0;
            flows_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            edge_count_reg <= edge_count_next;
            lat_pulses_reg <= lat_pulses_next;
            lat_period_reg <= lat_period_next;
            rate_zero_reg  <= rate_zero_next;
            run_p_reg      <= run_p_next;
            run_t_reg      <= run_t_next;
            flag_reg       <= flag_next;
            tot_p_reg      <= tot_p_next;
            tot_t_reg      <= tot_t_next;
            flows_reg      <= flows_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    fpd_pkg::CFG_MIN_PULSES:        min_pulses_reg <= cfg_data;
                    fpd_pkg::CFG_PULSES_PER_GALLON: ppg_reg        <= cfg_data;
                    default:                        ppg_reg        <= ppg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_shift_reg  <= p_shift_next;
        t_shift_reg  <= t_shift_next;
        nq_reg       <= nq_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

`include "flow_pulse_detector_assert.svh"

    `FPD_ASSERT_NXT(a_period_starts_mul, clk, rst_n, in_fire && s_axis_tuser == fpd_pkg::CMD_PERIOD, state_reg == ST_MUL && step_reg == '0 && edge_count_reg == '0, "period transfer did not start the multiplier")
    `FPD_ASSERT_IMP(a_den_stable_in_div, clk, rst_n, state_reg == ST_DIV && $past(state_reg) == ST_DIV, $stable(den_reg), "divisor changed during division")
    `FPD_ASSERT_NXT(a_done_loads_output, clk, rst_n, state_reg == ST_DONE && out_free, m_axis_tvalid && state_reg == ST_IDLE, "finished result was not loaded")

endmodule
